### src/sts_pkg.sv
package sts_pkg;

  localparam int KW_MAX_LEN = 11;
  localparam int KW_COUNT = 44;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_STR_ESC, M_PEND,
    M_LINE_CMT, M_BLOCK, M_BLOCK_STAR
  } mode_t;

  localparam logic [6:0] K_IDENT    = 7'd44;
  localparam logic [6:0] K_INT      = 7'd45;
  localparam logic [6:0] K_FLOAT    = 7'd46;
  localparam logic [6:0] K_STRING   = 7'd47;
  localparam logic [6:0] K_SEMI     = 7'd48;
  localparam logic [6:0] K_COMMA    = 7'd49;
  localparam logic [6:0] K_DOT      = 7'd50;
  localparam logic [6:0] K_LPAREN   = 7'd51;
  localparam logic [6:0] K_RPAREN   = 7'd52;
  localparam logic [6:0] K_STAR     = 7'd53;
  localparam logic [6:0] K_EQ       = 7'd54;
  localparam logic [6:0] K_NEQ      = 7'd55;
  localparam logic [6:0] K_LT       = 7'd56;
  localparam logic [6:0] K_GT       = 7'd57;
  localparam logic [6:0] K_LE       = 7'd58;
  localparam logic [6:0] K_GE       = 7'd59;
  localparam logic [6:0] K_PLUS     = 7'd60;
  localparam logic [6:0] K_MINUS    = 7'd61;
  localparam logic [6:0] K_DIV      = 7'd62;
  localparam logic [6:0] K_END      = 7'd63;
  localparam logic [6:0] K_UNKNOWN  = 7'd64;
  localparam logic [6:0] K_UNCLOSED = 7'd65;

  // keyword text, right-justified, in table order
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "SELECT", "INSERT", "INTO", "VALUES", "UPDATE", "DELETE", "CREATE",
    "DROP", "TABLE", "FROM", "WHERE", "SET", "AND", "OR", "NOT", "NULL",
    "TRUE", "FALSE", "PRIMARY", "KEY", "INDEX", "ON", "DEFAULT", "ORDER",
    "BY", "ASC", "DESC", "LIMIT", "AS", "DISTINCT", "EXISTS", "IN",
    "BETWEEN", "LIKE", "IS", "BEGIN", "COMMIT", "ROLLBACK", "SAVEPOINT",
    "RELEASE", "TRANSACTION", "ABORT", "START", "TO"
  };
  localparam int KW_LEN [KW_COUNT] = '{
    6, 6, 4, 6, 6, 6, 6, 4, 5, 4, 5, 3, 3, 2, 3, 4, 4, 5, 7, 3, 5, 2, 7, 5,
    2, 3, 4, 5, 2, 8, 6, 2, 7, 4, 2, 5, 6, 8, 9, 7, 11, 5, 5, 2
  };

  typedef struct packed {
    mode_t                             mode;
    logic [7:0]                        held;
    logic [KW_MAX_LEN-1:0][7:0]        letters;
    logic [4:0]                        wlen;
    logic [15:0]                       tstart;
    logic [15:0]                       tline;
    logic [15:0]                       tcol;
    logic [15:0]                       pos;
    logic [15:0]                       line;
    logic [15:0]                       col;
    logic                              done;
  } scan_state_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] span;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } result_t;

  // case-insensitive keyword lookup over stored upper-case letters
  function automatic logic [6:0] kw_kind(input logic [KW_MAX_LEN-1:0][7:0] lt,
                                         input logic [4:0] wl);
    logic [6:0] k;
    logic       hit;
    int         idx;
    k = K_IDENT;
    for (int j = KW_COUNT - 1; j >= 0; j--) begin
      hit = (wl == 5'(KW_LEN[j]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        // byte position of letter i inside the right-justified text
        idx = (i < KW_LEN[j]) ? (KW_LEN[j] - 1 - i) : 0;
        if (i < KW_LEN[j] && lt[i] != KW_TEXT[j][8*idx +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = 7'(j);
      end
    end
    return k;
  endfunction

endpackage

### src/sts_step.sv
module sts_step (
  input  sts_pkg::scan_state_t s,
  input  logic [7:0]           c,
  input  logic                 last,
  output sts_pkg::scan_state_t n,
  output sts_pkg::result_t     res [3],
  output logic [1:0]           cnt
);
  import sts_pkg::*;

  function automatic logic [15:0] sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic scan_state_t consume(input scan_state_t v, input logic [7:0] b);
    scan_state_t r;
    r = v;
    r.pos = sat(v.pos);
    if (b == 8'h0A) begin
      r.line = sat(v.line);
      r.col = 16'd1;
    end else begin
      r.col = sat(v.col);
    end
    return r;
  endfunction

  function automatic scan_state_t add_letter(input scan_state_t v, input logic [7:0] b);
    scan_state_t r;
    logic [7:0]  u;
    r = v;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    if (v.wlen < 5'(KW_MAX_LEN)) begin
      r.letters[v.wlen[3:0]] = u;
    end
    if (v.wlen <= 5'(KW_MAX_LEN)) begin
      r.wlen = v.wlen + 5'd1;
    end
    return r;
  endfunction

  function automatic logic [6:0] pend_single(input logic [7:0] h);
    case (h)
      "-":     return K_MINUS;
      "/":     return K_DIV;
      "<":     return K_LT;
      ">":     return K_GT;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [6:0] punct_kind(input logic [7:0] b);
    case (b)
      ";":     return K_SEMI;
      ",":     return K_COMMA;
      ".":     return K_DOT;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "*":     return K_STAR;
      "+":     return K_PLUS;
      "=":     return K_EQ;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic result_t tok(input scan_state_t v, input logic [6:0] k);
    result_t r;
    r.kind = k;
    r.start = v.tstart;
    r.span = v.pos - v.tstart;
    r.line = v.tline;
    r.col = v.tcol;
    r.last = 1'b0;
    return r;
  endfunction

  logic       is_alpha, is_digit, is_word, is_space, rescan;
  logic [7:0] h;

  assign is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_word  = is_alpha || is_digit || c == "_";
  assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign h = s.held;

  // one byte of scanning, then optional end-of-stream flush
  always_comb begin
    n = s;
    cnt = '0;
    rescan = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    if (!s.done) begin
      if (c != 8'd0) begin
        // continue the token in progress
        case (s.mode)
          M_IDENT: begin
            if (is_word) begin
              n = add_letter(consume(n, c), c);
            end else begin
              res[cnt] = tok(n, kw_kind(n.letters, n.wlen));
              cnt = cnt + 2'd1;
              rescan = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit) begin
              n = consume(n, c);
            end else if (c == ".") begin
              n = consume(n, c);
              n.mode = M_FRAC;
            end else begin
              res[cnt] = tok(n, K_INT);
              cnt = cnt + 2'd1;
              rescan = 1'b1;
            end
          end
          M_FRAC: begin
            if (is_digit) begin
              n = consume(n, c);
            end else begin
              res[cnt] = tok(n, K_FLOAT);
              cnt = cnt + 2'd1;
              rescan = 1'b1;
            end
          end
          M_STR: begin
            n = consume(n, c);
            if (c == "\\") begin
              n.mode = M_STR_ESC;
            end else if (c == "'") begin
              res[cnt] = tok(n, K_STRING);
              cnt = cnt + 2'd1;
              n.mode = M_IDLE;
            end
          end
          M_STR_ESC: begin
            n = consume(n, c);
            n.mode = M_STR;
          end
          M_PEND: begin
            if (h == "-" && c == "-") begin
              n = consume(n, c);
              n.mode = M_LINE_CMT;
            end else if (h == "/" && c == "*") begin
              n = consume(n, c);
              n.mode = M_BLOCK;
            end else if (c == "=" && (h == "!" || h == "<" || h == ">")) begin
              n = consume(n, c);
              res[cnt] = tok(n, (h == "!") ? K_NEQ : ((h == "<") ? K_LE : K_GE));
              cnt = cnt + 2'd1;
              n.mode = M_IDLE;
            end else begin
              res[cnt] = tok(n, pend_single(h));
              cnt = cnt + 2'd1;
              rescan = 1'b1;
            end
          end
          M_LINE_CMT: begin
            n = consume(n, c);
            if (c == 8'h0A) begin
              n.mode = M_IDLE;
            end
          end
          M_BLOCK: begin
            n = consume(n, c);
            if (c == "*") begin
              n.mode = M_BLOCK_STAR;
            end
          end
          M_BLOCK_STAR: begin
            n = consume(n, c);
            if (c == "/") begin
              n.mode = M_IDLE;
            end else if (c != "*") begin
              n.mode = M_BLOCK;
            end
          end
          default: rescan = 1'b1;
        endcase

        // start a new token from idle
        if (rescan) begin
          n.mode = M_IDLE;
          if (is_space) begin
            n = consume(n, c);
          end else begin
            n.tstart = n.pos;
            n.tline = n.line;
            n.tcol = n.col;
            n = consume(n, c);
            if (is_alpha || c == "_") begin
              n.wlen = '0;
              n = add_letter(n, c);
              n.mode = M_IDENT;
            end else if (is_digit) begin
              n.mode = M_INT;
            end else if (c == "'") begin
              n.mode = M_STR;
            end else if (c == "-" || c == "/" || c == "!" || c == "<" || c == ">") begin
              n.held = c;
              n.mode = M_PEND;
            end else begin
              res[cnt] = tok(n, punct_kind(c));
              cnt = cnt + 2'd1;
            end
          end
        end
      end

      // end of stream: flush pending token, then END
      if (c == 8'd0 || last) begin
        case (n.mode)
          M_IDENT: begin
            res[cnt] = tok(n, kw_kind(n.letters, n.wlen));
            cnt = cnt + 2'd1;
          end
          M_INT: begin
            res[cnt] = tok(n, K_INT);
            cnt = cnt + 2'd1;
          end
          M_FRAC: begin
            res[cnt] = tok(n, K_FLOAT);
            cnt = cnt + 2'd1;
          end
          M_STR, M_STR_ESC: begin
            res[cnt] = tok(n, K_STRING);
            cnt = cnt + 2'd1;
          end
          M_PEND: begin
            res[cnt] = tok(n, pend_single(n.held));
            cnt = cnt + 2'd1;
          end
          M_BLOCK, M_BLOCK_STAR: begin
            res[cnt] = tok(n, K_UNCLOSED);
            cnt = cnt + 2'd1;
          end
          default: ;
        endcase
        n.mode = M_IDLE;
        res[cnt].kind = K_END;
        res[cnt].start = n.pos;
        res[cnt].span = '0;
        res[cnt].line = n.line;
        res[cnt].col = n.col;
        res[cnt].last = 1'b0;
        cnt = cnt + 2'd1;
        n.done = 1'b1;
      end
    end
    if (cnt != 2'd0) begin
      res[cnt - 2'd1].last = 1'b1;
    end
  end

endmodule

### src/sts_outq.sv
module sts_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sts_pkg::result_t push_res [3],
  input  logic [1:0]       push_cnt,
  input  logic             pop,
  output logic             can_push,
  output logic             not_empty,
  output sts_pkg::result_t head
);
  import sts_pkg::*;

  result_t    q [3];
  logic [1:0] qcnt;

  // room when empty, or when the only entry leaves this cycle
  assign can_push  = (qcnt == 2'd0) || (qcnt == 2'd1 && pop);
  assign not_empty = (qcnt != 2'd0);
  assign head      = q[0];

  // queue count
  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
    end else if (push) begin
      qcnt <= push_cnt;
    end else if (pop) begin
      qcnt <= qcnt - 2'd1;
    end
  end

  // payload: load on push, shift toward head on pop
  always_ff @(posedge clk) begin
    if (push) begin
      q <= push_res;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

endmodule

### src/sql_token_scanner.sv
// sql_token_scanner: streaming sql lexer, one byte per transaction
// output: the tokens of an accepted byte are registered in the result queue
// throughput: one byte per cycle while each byte yields at most one token and the output is not stalled;
//   a byte yielding more tokens stalls the input until its last result is popped
// reset: synchronous, active high; scanner idle at offset 0, line 1, column 1
module sql_token_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] span_length,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic        last_in_run
);
  import sts_pkg::*;

  scan_state_t st, st_next;
  result_t     res [3];
  result_t     head;
  logic [1:0]  cnt;
  logic        can_push, not_empty, take_in, take_out;

  sts_step u_step (
    .s    (st),
    .c    (data_byte),
    .last (is_last),
    .n    (st_next),
    .res  (res),
    .cnt  (cnt)
  );

  assign take_out = not_empty && !out_stall;
  assign take_in  = in_valid && can_push;
  assign in_stall = !can_push;

  sts_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take_in),
    .push_res  (res),
    .push_cnt  (cnt),
    .pop       (take_out),
    .can_push  (can_push),
    .not_empty (not_empty),
    .head      (head)
  );

  // scanner state; word letters are not reset
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode <= M_IDLE;
      st.held <= '0;
      st.wlen <= '0;
      st.tstart <= '0;
      st.tline <= 16'd1;
      st.tcol <= 16'd1;
      st.pos <= '0;
      st.line <= 16'd1;
      st.col <= 16'd1;
      st.done <= 1'b0;
    end else if (take_in) begin
      st.mode <= st_next.mode;
      st.held <= st_next.held;
      st.letters <= st_next.letters;
      st.wlen <= st_next.wlen;
      st.tstart <= st_next.tstart;
      st.tline <= st_next.tline;
      st.tcol <= st_next.tcol;
      st.pos <= st_next.pos;
      st.line <= st_next.line;
      st.col <= st_next.col;
      st.done <= st_next.done;
    end
  end

  assign out_valid    = not_empty;
  assign token_kind   = head.kind;
  assign start_offset = head.start;
  assign span_length  = head.span;
  assign start_line   = head.line;
  assign start_column = head.col;
  assign last_in_run  = head.last;

endmodule
